>>> hdl/cbd_pkg.sv
// ----------------------------------------------------------------------------
// cbd_pkg
// Shared types and constants of the CBOR head stream decoder.
// ----------------------------------------------------------------------------
package cbd_pkg;

   // field widths
   localparam int BYTE_W = 8;
   localparam int MAJOR_W = 3;
   localparam int SIZE_W = 2;
   localparam int ARG_W = 64;
   localparam int ARG_LEFT_W = 4;

   // head byte layout
   localparam logic [BYTE_W-1:0] MAJOR_MASK = 8'hE0;
   localparam int MAJOR_SHIFT = 5;
   localparam logic [4:0] AI_INLINE_LIMIT = 5'd24;
   localparam logic [4:0] AI_ARG_MAX = 5'd27;

   // major types with special handling
   localparam logic [MAJOR_W-1:0] MAJOR_NEG_INT = 3'd1;
   localparam logic [MAJOR_W-1:0] MAJOR_BYTES = 3'd2;
   localparam logic [MAJOR_W-1:0] MAJOR_TEXT = 3'd3;
   localparam logic [MAJOR_W-1:0] MAJOR_SIMPLE = 3'd7;

   // result queue depth
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_HEAD    = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_ERROR   = 2'd2
   } item_kind_type;

   typedef enum logic [1:0] {
      ERR_NONE          = 2'd0,
      ERR_RESERVED_AI   = 2'd1,
      ERR_TRUNC_ARG     = 2'd2,
      ERR_TRUNC_PAYLOAD = 2'd3
   } error_code_type;

   typedef enum logic [2:0] {
      PH_HEAD    = 3'b001,
      PH_ARG     = 3'b010,
      PH_PAYLOAD = 3'b100
   } phase_type;

   // one decoded result, plus a flag for a trailing truncated payload error
   typedef struct packed {
      item_kind_type        kind;
      logic [MAJOR_W-1:0]   major;
      logic [SIZE_W-1:0]    size_class;
      logic [ARG_W-1:0]     argument;
      logic                 signed_overflow;
      logic [BYTE_W-1:0]    payload_byte;
      logic                 payload_last;
      error_code_type       error_code;
      logic                 trunc_follow;
   } result_type;

endpackage

>>> hdl/cbd_req_if.sv
// ----------------------------------------------------------------------------
// cbd_req_if
// Byte stream channel into the decoder: valid/ready with one byte per item.
// ----------------------------------------------------------------------------
interface cbd_req_if import cbd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;
   logic              buffer_end;

   modport source (output valid, output in_byte, output buffer_end, input ready);
   modport sink (input valid, input in_byte, input buffer_end, output ready);
endinterface

>>> hdl/cbd_rsp_if.sv
// ----------------------------------------------------------------------------
// cbd_rsp_if
// Result channel out of the decoder: valid/ready with one result per item.
// ----------------------------------------------------------------------------
interface cbd_rsp_if import cbd_pkg::*; ();
   logic               valid;
   logic               ready;
   item_kind_type      item_kind;
   logic [MAJOR_W-1:0] item_major;
   logic [SIZE_W-1:0]  size_class;
   logic [ARG_W-1:0]   argument;
   logic               signed_overflow;
   logic [BYTE_W-1:0]  payload_byte;
   logic               payload_last;
   error_code_type     error_code;
   logic               run_last;

   modport source (output valid, output item_kind, output item_major, output size_class,
                   output argument, output signed_overflow, output payload_byte,
                   output payload_last, output error_code, output run_last, input ready);
   modport sink (input valid, input item_kind, input item_major, input size_class,
                 input argument, input signed_overflow, input payload_byte,
                 input payload_last, input error_code, input run_last, output ready);
endinterface

>>> hdl/cbd_head_decoder.sv
// ----------------------------------------------------------------------------
// cbd_head_decoder
// Input register and head/argument/payload state machine; one byte a cycle while the queue has space.
// ----------------------------------------------------------------------------
module cbd_head_decoder import cbd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   cbd_req_if.sink    req,
   input  logic       queue_space,
   output logic       push,
   output result_type push_result
);

   logic                  in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0]     in_byte_ff;
   logic                  in_end_ff;
   logic                  consume;
   logic                  req_fire;

   phase_type             phase_ff, phase_in;
   logic [MAJOR_W-1:0]    major_ff, major_in;
   logic [SIZE_W-1:0]     size_ff, size_in;
   logic [ARG_LEFT_W-1:0] arg_left_ff, arg_left_in;
   logic [ARG_W-1:0]      acc_ff, acc_in;
   logic [ARG_W-1:0]      pay_left_ff, pay_left_in;

   logic [ARG_W-1:0]      acc_next;
   logic [ARG_LEFT_W-1:0] arg_left_dec;
   logic [ARG_W-1:0]      pay_left_dec;
   logic [4:0]            head_ai;
   logic [MAJOR_W-1:0]    head_major;
   logic                  finish;
   logic [ARG_W-1:0]      finish_arg;
   logic                  have_result;
   result_type            res;

   // input register, refilled whenever the held byte is decoded
   assign consume = in_valid_ff & queue_space;
   assign req.ready = ~in_valid_ff | consume;
   assign req_fire = req.valid & req.ready;
   assign in_valid_in = req_fire | (in_valid_ff & ~consume);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_fire) begin
         in_byte_ff <= req.in_byte;
         in_end_ff <= req.buffer_end;
      end
   end

   // byte decode against the current phase
   assign acc_next = {acc_ff[ARG_W-BYTE_W-1:0], in_byte_ff};
   assign arg_left_dec = arg_left_ff - ARG_LEFT_W'(1);
   assign pay_left_dec = pay_left_ff - ARG_W'(1);
   assign head_ai = in_byte_ff[4:0];
   assign head_major = MAJOR_W'((in_byte_ff & MAJOR_MASK) >> MAJOR_SHIFT);

   always_comb begin
      phase_in = phase_ff;
      major_in = major_ff;
      size_in = size_ff;
      arg_left_in = arg_left_ff;
      acc_in = acc_ff;
      pay_left_in = pay_left_ff;
      finish = 1'b0;
      finish_arg = '0;
      have_result = 1'b0;
      res = '0;
      res.kind = KIND_HEAD;
      res.error_code = ERR_NONE;

      unique case (phase_ff)
         PH_ARG: begin
            acc_in = acc_next;
            arg_left_in = arg_left_dec;
            if (arg_left_dec == '0) begin
               finish = 1'b1;
               finish_arg = acc_next;
            end else if (in_end_ff) begin
               have_result = 1'b1;
               res.kind = KIND_ERROR;
               res.major = major_ff;
               res.size_class = size_ff;
               res.error_code = ERR_TRUNC_ARG;
               phase_in = PH_HEAD;
            end
         end
         PH_PAYLOAD: begin
            pay_left_in = pay_left_dec;
            have_result = 1'b1;
            res.kind = KIND_PAYLOAD;
            res.major = major_ff;
            res.size_class = size_ff;
            res.payload_byte = in_byte_ff;
            res.payload_last = (pay_left_dec == '0);
            if (pay_left_dec == '0) begin
               phase_in = PH_HEAD;
            end
         end
         default: begin
            // head byte, also taken for any unused phase code
            major_in = head_major;
            size_in = '0;
            if (head_major == MAJOR_SIMPLE) begin
               have_result = 1'b1;
               res.major = head_major;
               res.argument = ARG_W'(in_byte_ff);
               phase_in = PH_HEAD;
            end else if (head_ai < AI_INLINE_LIMIT) begin
               finish = 1'b1;
               finish_arg = ARG_W'(head_ai);
            end else if (head_ai <= AI_ARG_MAX) begin
               size_in = head_ai[1:0];
               arg_left_in = ARG_LEFT_W'(1) << head_ai[1:0];
               acc_in = '0;
               if (in_end_ff) begin
                  have_result = 1'b1;
                  res.kind = KIND_ERROR;
                  res.major = head_major;
                  res.size_class = head_ai[1:0];
                  res.error_code = ERR_TRUNC_ARG;
                  phase_in = PH_HEAD;
               end else begin
                  phase_in = PH_ARG;
               end
            end else begin
               have_result = 1'b1;
               res.kind = KIND_ERROR;
               res.major = head_major;
               res.error_code = ERR_RESERVED_AI;
               phase_in = PH_HEAD;
            end
         end
      endcase

      // completed head; strings with a non-zero length go on to payload
      if (finish) begin
         have_result = 1'b1;
         res.kind = KIND_HEAD;
         res.major = major_in;
         res.size_class = size_in;
         res.argument = finish_arg;
         res.signed_overflow = (major_in <= MAJOR_NEG_INT) & finish_arg[ARG_W-1];
         if (((major_in == MAJOR_BYTES) || (major_in == MAJOR_TEXT)) && (finish_arg != '0)) begin
            pay_left_in = finish_arg;
            phase_in = PH_PAYLOAD;
         end else begin
            phase_in = PH_HEAD;
         end
      end

      // buffer end: flag a cut-off string and go back to expecting a head
      if (in_end_ff) begin
         res.trunc_follow = (phase_in == PH_PAYLOAD);
         phase_in = PH_HEAD;
         arg_left_in = '0;
      end
   end

   assign push = consume & have_result;
   assign push_result = res;

   // decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEAD;
      end else if (consume) begin
         phase_ff <= phase_in;
      end
      if (consume) begin
         major_ff <= major_in;
         size_ff <= size_in;
         arg_left_ff <= arg_left_in;
         acc_ff <= acc_in;
         pay_left_ff <= pay_left_in;
      end
   end

endmodule

>>> hdl/cbd_result_queue.sv
// ----------------------------------------------------------------------------
// cbd_result_queue
// Small result queue; an entry flagged for truncation goes out as two items.
// ----------------------------------------------------------------------------
module cbd_result_queue import cbd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_result,
   output logic       queue_space,
   cbd_rsp_if.source  rsp
);

   result_type             entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   second_ff, second_in;
   result_type             head;
   logic                   rsp_fire;
   logic                   pop;

   assign queue_space = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head = entry_ff[rd_ptr_ff];

   // output fields; the second beat is the truncated payload error
   always_comb begin
      rsp.valid = (count_ff != '0);
      rsp.item_kind = head.kind;
      rsp.item_major = head.major;
      rsp.size_class = head.size_class;
      rsp.argument = head.argument;
      rsp.signed_overflow = head.signed_overflow;
      rsp.payload_byte = head.payload_byte;
      rsp.payload_last = head.payload_last;
      rsp.error_code = head.error_code;
      rsp.run_last = ~head.trunc_follow;
      if (second_ff) begin
         rsp.item_kind = KIND_ERROR;
         rsp.argument = '0;
         rsp.signed_overflow = 1'b0;
         rsp.payload_byte = '0;
         rsp.payload_last = 1'b0;
         rsp.error_code = ERR_TRUNC_PAYLOAD;
         rsp.run_last = 1'b1;
      end
   end

   // pointer and count bookkeeping
   assign rsp_fire = rsp.valid & rsp.ready;
   assign pop = rsp_fire & (second_ff | ~head.trunc_follow);
   assign second_in = rsp_fire ? ~pop : second_ff;
   assign wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                      : wr_ptr_ff + QUEUE_PTR_W'(1);
   assign rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                      : rd_ptr_ff + QUEUE_PTR_W'(1);
   assign count_in = count_ff + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
         second_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         second_ff <= second_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_in;
         end
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_result;
      end
   end

endmodule

>>> hdl/cbor_head_stream_decoder.sv
// ----------------------------------------------------------------------------
// cbor_head_stream_decoder
// CBOR head decoder for a byte stream, reader side only.
// ----------------------------------------------------------------------------
// req_stream carries one stream byte per item together with buffer_end, set
// on the last byte of a buffer. rsp_stream carries decoded heads, string
// payload bytes and errors; run_last marks the last result of a byte.
// A byte is held in an input register, decoded there and written into the
// two-entry result queue once an entry is free; its first result is then
// offered from the queue. Throughput is one byte per cycle while the queue
// has a free entry, set by the single decode stage. A byte that also ends a
// string early gives two results and holds its queue entry until both have
// been taken.
// Argument bytes of a head give no result until the last one arrives or the buffer ends.
// Reset returns the decoder to expecting a head byte and empties the queue.
// When the receiver stalls, the queue fills and req_stream.ready falls once
// the held byte has no free entry to go to; no item is lost.
// ----------------------------------------------------------------------------
module cbor_head_stream_decoder import cbd_pkg::*; (
   input logic       clock,
   input logic       reset,
   cbd_req_if.sink   req_stream,
   cbd_rsp_if.source rsp_stream
);

   logic       queue_space;
   logic       push;
   result_type push_result;

   // byte decode and state
   cbd_head_decoder u_decoder (
      .clock       (clock),
      .reset       (reset),
      .req         (req_stream),
      .queue_space (queue_space),
      .push        (push),
      .push_result (push_result)
   );

   // result buffering towards the receiver
   cbd_result_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_result (push_result),
      .queue_space (queue_space),
      .rsp         (rsp_stream)
   );

endmodule

>>> dv/cbor_head_stream_decoder_checker.sv
// ----------------------------------------------------------------------------
// cbor_head_stream_decoder_checker
// Watches both channels of the CBOR head decoder. Each byte it sees accepted
// goes through a cycle-free decoder written here, and the results that byte
// should cause are queued. Each result taken from the block is compared
// field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module cbor_head_stream_decoder_checker import cbd_pkg::*; (
   input  logic clock,
   input  logic reset,
   cbd_req_if   req_mon,
   cbd_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending,
   output int   head_count,
   output int   payload_count,
   output int   error_count
);

   typedef enum logic [1:0] {
      WAIT_HEAD,
      TAKE_ARG,
      TAKE_PAYLOAD
   } decode_phase_type;

   typedef struct packed {
      item_kind_type      kind;
      logic [MAJOR_W-1:0] major;
      logic [SIZE_W-1:0]  size_class;
      logic [ARG_W-1:0]   argument;
      logic               overflow;
      logic [BYTE_W-1:0]  payload_byte;
      logic               payload_last;
      error_code_type     error_code;
      logic               run_last;
   } cbor_result_type;

   // decoder state as the block should hold it
   decode_phase_type       phase;
   logic [MAJOR_W-1:0]     cur_major;
   logic [SIZE_W-1:0]      cur_size;
   logic [ARG_LEFT_W-1:0]  arg_left;
   logic [ARG_W-1:0]       arg_acc;
   logic [ARG_W-1:0]       payload_left;

   cbor_result_type expected_results[$];
   cbor_result_type byte_results[$];

   int mismatches = 0;
   int heads_seen = 0;
   int payloads_seen = 0;
   int errors_seen = 0;
   int queued = 0;

   assign fail_count = mismatches;
   assign pending = queued;
   assign head_count = heads_seen;
   assign payload_count = payloads_seen;
   assign error_count = errors_seen;

   function automatic cbor_result_type make_result(item_kind_type kind,
                                                   logic [MAJOR_W-1:0] major,
                                                   logic [SIZE_W-1:0] sc, logic [ARG_W-1:0] arg,
                                                   logic ovf, logic [BYTE_W-1:0] pb, logic pl,
                                                   error_code_type err);
      cbor_result_type r;
      r.kind = kind;
      r.major = major;
      r.size_class = sc;
      r.argument = arg;
      r.overflow = ovf;
      r.payload_byte = pb;
      r.payload_last = pl;
      r.error_code = err;
      r.run_last = 1'b0;
      return r;
   endfunction

   // head is complete: report it and open the payload of a non-empty string
   function automatic void complete_head(logic [ARG_W-1:0] arg);
      logic ovf;
      ovf = (cur_major <= MAJOR_NEG_INT) && arg[ARG_W-1];
      byte_results.push_back(make_result(KIND_HEAD, cur_major, cur_size, arg, ovf,
                                         '0, 1'b0, ERR_NONE));
      if ((cur_major == MAJOR_BYTES || cur_major == MAJOR_TEXT) && arg != '0) begin
         payload_left = arg;
         phase = TAKE_PAYLOAD;
      end else begin
         phase = WAIT_HEAD;
      end
   endfunction

   // expected results of one stream byte
   function automatic void decode_byte(logic [BYTE_W-1:0] b, logic last);
      logic [4:0] ai;
      byte_results.delete();
      case (phase)
         TAKE_ARG: begin
            arg_acc = {arg_acc[ARG_W-BYTE_W-1:0], b};
            arg_left = arg_left - 1'b1;
            if (arg_left == '0) begin
               complete_head(arg_acc);
            end else if (last) begin
               byte_results.push_back(make_result(KIND_ERROR, cur_major, cur_size, '0, 1'b0,
                                                  '0, 1'b0, ERR_TRUNC_ARG));
               phase = WAIT_HEAD;
            end
         end
         TAKE_PAYLOAD: begin
            payload_left = payload_left - 1'b1;
            byte_results.push_back(make_result(KIND_PAYLOAD, cur_major, cur_size, '0, 1'b0,
                                               b, payload_left == '0, ERR_NONE));
            if (payload_left == '0) phase = WAIT_HEAD;
         end
         default: begin
            ai = b[4:0];
            cur_major = MAJOR_W'((b & MAJOR_MASK) >> MAJOR_SHIFT);
            cur_size = '0;
            if (cur_major == MAJOR_SIMPLE) begin
               // simple values pass through as the raw head byte
               byte_results.push_back(make_result(KIND_HEAD, MAJOR_SIMPLE, '0, ARG_W'(b), 1'b0,
                                                  '0, 1'b0, ERR_NONE));
               phase = WAIT_HEAD;
            end else if (ai < AI_INLINE_LIMIT) begin
               complete_head(ARG_W'(ai));
            end else if (ai <= AI_ARG_MAX) begin
               cur_size = SIZE_W'(ai - AI_INLINE_LIMIT);
               arg_left = ARG_LEFT_W'(1) << cur_size;
               arg_acc = '0;
               if (last) begin
                  byte_results.push_back(make_result(KIND_ERROR, cur_major, cur_size, '0, 1'b0,
                                                     '0, 1'b0, ERR_TRUNC_ARG));
                  phase = WAIT_HEAD;
               end else begin
                  phase = TAKE_ARG;
               end
            end else begin
               byte_results.push_back(make_result(KIND_ERROR, cur_major, '0, '0, 1'b0,
                                                  '0, 1'b0, ERR_RESERVED_AI));
               phase = WAIT_HEAD;
            end
         end
      endcase

      // end of buffer: a string still owed payload is cut short
      if (last) begin
         if (phase == TAKE_PAYLOAD && byte_results.size() < 2)
            byte_results.push_back(make_result(KIND_ERROR, cur_major, cur_size, '0, 1'b0,
                                               '0, 1'b0, ERR_TRUNC_PAYLOAD));
         phase = WAIT_HEAD;
         arg_left = '0;
      end

      if (byte_results.size() > 0) begin
         byte_results[byte_results.size()-1].run_last = 1'b1;
         foreach (byte_results[i]) expected_results.push_back(byte_results[i]);
      end
   endfunction

   task automatic check_field(string name, logic [ARG_W-1:0] exp_v, logic [ARG_W-1:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
         mismatches++;
      end
   endtask

   // compare results first, then predict from the byte taken at this edge
   always @(posedge clock) begin
      cbor_result_type want;
      if (reset) begin
         phase = WAIT_HEAD;
         cur_major = '0;
         cur_size = '0;
         arg_left = '0;
         arg_acc = '0;
         payload_left = '0;
         expected_results.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result: kind 0x%0h major 0x%0h argument 0x%0h",
                      rsp_mon.item_kind, rsp_mon.item_major, rsp_mon.argument);
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               check_field("item_kind", ARG_W'(want.kind), ARG_W'(rsp_mon.item_kind));
               check_field("item_major", ARG_W'(want.major), ARG_W'(rsp_mon.item_major));
               check_field("size_class", ARG_W'(want.size_class), ARG_W'(rsp_mon.size_class));
               check_field("argument", want.argument, rsp_mon.argument);
               check_field("signed_overflow", ARG_W'(want.overflow),
                           ARG_W'(rsp_mon.signed_overflow));
               check_field("payload_byte", ARG_W'(want.payload_byte),
                           ARG_W'(rsp_mon.payload_byte));
               check_field("payload_last", ARG_W'(want.payload_last),
                           ARG_W'(rsp_mon.payload_last));
               check_field("error_code", ARG_W'(want.error_code), ARG_W'(rsp_mon.error_code));
               check_field("run_last", ARG_W'(want.run_last), ARG_W'(rsp_mon.run_last));
               case (want.kind)
                  KIND_HEAD:    heads_seen++;
                  KIND_PAYLOAD: payloads_seen++;
                  default:      errors_seen++;
               endcase
            end
         end
         if (req_mon.valid && req_mon.ready)
            decode_byte(req_mon.in_byte, req_mon.buffer_end);
      end
      queued = expected_results.size();
   end

endmodule

>>> dv/cbor_head_stream_decoder_test.sv
// ----------------------------------------------------------------------------
// cbor_head_stream_decoder_test
// Stimulus and verdict for the CBOR head stream decoder. A short directed
// stream covers extreme heads, every major type, a reserved code, an empty
// string and buffers cut inside arguments and payloads; a longer stream of
// random well-formed items with noise and early buffer ends follows. Both
// channels idle in random bursts; the checker beside the block does all
// prediction and comparison.
// ----------------------------------------------------------------------------
module cbor_head_stream_decoder_test;
   import cbd_pkg::*;

   localparam int ITEM_TARGET = 650;
   localparam int WATCHDOG_LIMIT = 500;
   localparam int DRAIN_CYCLES = 20;
   localparam int CALM_TAIL = 100;

   typedef struct packed {
      logic [BYTE_W-1:0] value;
      logic              last;
   } stream_byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic quiet = 1'b0;
   int   idle_cycles = 0;
   int   fail_count;
   int   pending;
   int   head_count;
   int   payload_count;
   int   error_count;

   stream_byte_type stream_q[$];

   cbd_req_if req_stream ();
   cbd_rsp_if rsp_stream ();

   cbor_head_stream_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_stream (req_stream),
      .rsp_stream (rsp_stream)
   );

   cbor_head_stream_decoder_checker decode_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_stream),
      .rsp_mon       (rsp_stream),
      .fail_count    (fail_count),
      .pending       (pending),
      .head_count    (head_count),
      .payload_count (payload_count),
      .error_count   (error_count)
   );

   always #5 clock = ~clock;

   function automatic void push_byte(logic [BYTE_W-1:0] value, logic last);
      stream_byte_type s;
      s.value = value;
      s.last = last;
      stream_q.push_back(s);
   endfunction

   // directed stream: extremes, each major type and each special case
   task automatic add_directed();
      push_byte(8'h00, 1'b0);                        // smallest inline integer
      push_byte(8'h17, 1'b0);                        // largest inline integer
      push_byte(8'h18, 1'b0);
      push_byte(8'hFF, 1'b0);                        // one argument byte, all ones
      push_byte(8'h1B, 1'b0);
      repeat (8) push_byte(8'hFF, 1'b0);             // eight bytes, past signed range
      push_byte(8'h1C, 1'b0);                        // reserved additional information
      push_byte(8'hFF, 1'b0);                        // simple value, raw byte
      push_byte(8'h40, 1'b0);                        // empty byte string
      push_byte(8'h62, 1'b0);
      push_byte(8'h61, 1'b0);
      push_byte(8'h62, 1'b0);                        // two byte text string
      push_byte(8'h99, 1'b0);
      push_byte(8'h00, 1'b1);                        // buffer ends inside an argument
      push_byte(8'h5A, 1'b1);                        // buffer ends on the head itself
      push_byte(8'h43, 1'b0);
      push_byte(8'h01, 1'b1);                        // buffer ends inside a payload
      push_byte(8'h61, 1'b1);                        // string head ends the buffer
      push_byte(8'hA5, 1'b0);                        // map
      push_byte(8'hC0, 1'b0);                        // tag
      push_byte(8'h20, 1'b1);                        // negative integer, clean end
   endtask

   // one random data item, sometimes noise, sometimes cut short
   task automatic add_random_item();
      logic [BYTE_W-1:0] item_bytes[$];
      logic [MAJOR_W-1:0] major;
      logic [SIZE_W-1:0] sc;
      logic [ARG_W-1:0] value;
      int form;
      int pick;
      int cut;
      int ending;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         push_byte(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
         return;
      end
      if (pick < 12) begin
         push_byte({MAJOR_W'($urandom_range(0, 7)), 5'($urandom_range(28, 31))},
                   $urandom_range(0, 7) == 0);
         return;
      end

      major = MAJOR_W'($urandom_range(0, 7));
      form = $urandom_range(0, 4);
      if (major == MAJOR_SIMPLE) begin
         item_bytes.push_back({MAJOR_SIMPLE, 5'($urandom_range(0, 31))});
      end else begin
         // strings stay short whatever their encoding; numbers use the full width
         if (major == MAJOR_BYTES || major == MAJOR_TEXT) begin
            value = ($urandom_range(0, 9) == 0) ? ARG_W'($urandom_range(7, 30))
                                                : ARG_W'($urandom_range(0, 6));
            if (form == 0 && value >= ARG_W'(AI_INLINE_LIMIT)) form = 1;
         end else begin
            value = {$urandom, $urandom};
            case ($urandom_range(0, 5))
               0:       value = '0;
               1:       value = '1;
               default: ;
            endcase
            if (form == 0) value = ARG_W'($urandom_range(0, 23));
         end
         if (form == 0) begin
            item_bytes.push_back({major, value[4:0]});
         end else begin
            sc = SIZE_W'(form - 1);
            if (sc != 2'd3) value = value & ((ARG_W'(1) << (8 << sc)) - 1'b1);
            item_bytes.push_back({major, 5'(AI_INLINE_LIMIT + sc)});
            for (int i = (1 << sc) - 1; i >= 0; i--) item_bytes.push_back(value[8*i +: 8]);
         end
         if (major == MAJOR_BYTES || major == MAJOR_TEXT)
            for (int i = 0; i < int'(value); i++)
               item_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
      end

      ending = $urandom_range(0, 99);
      if (ending < 8 && item_bytes.size() > 1)
         cut = $urandom_range(0, item_bytes.size() - 2);
      else
         cut = item_bytes.size() - 1;
      for (int i = 0; i <= cut; i++)
         push_byte(item_bytes[i], (i == cut) && (cut < item_bytes.size() - 1 || ending < 20));
   endtask

   // byte source: reset, then the stream with random gaps
   initial begin
      int next_idx;
      int taken;
      int gap;
      int directed_count;
      next_idx = 0;
      taken = 0;
      gap = 0;
      req_stream.valid <= 1'b0;
      req_stream.in_byte <= '0;
      req_stream.buffer_end <= 1'b0;

      add_directed();
      directed_count = stream_q.size();
      while (stream_q.size() < ITEM_TARGET) add_random_item();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (taken < stream_q.size()) begin
         @(posedge clock);
         if (req_stream.valid && req_stream.ready) taken++;
         quiet <= (next_idx + CALM_TAIL >= stream_q.size()) || ((next_idx / 80) % 3 == 2);
         if (!req_stream.valid || req_stream.ready) begin
            if (gap > 0) begin
               gap--;
               req_stream.valid <= 1'b0;
            end else if (next_idx < stream_q.size()) begin
               req_stream.valid <= 1'b1;
               req_stream.in_byte <= stream_q[next_idx].value;
               req_stream.buffer_end <= stream_q[next_idx].last;
               next_idx++;
               if (!quiet && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 11);
            end else begin
               req_stream.valid <= 1'b0;
            end
         end
      end

      // let the last results drain, then give the verdict
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      $display("%0d stream bytes (%0d directed) decoded into %0d results:",
               stream_q.size(), directed_count, head_count + payload_count + error_count);
      $display("%0d heads, %0d payload bytes, %0d errors", head_count, payload_count,
               error_count);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // result sink: random stall bursts
   initial begin
      int stall;
      stall = 0;
      rsp_stream.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_stream.ready <= 1'b0;
         end else if (stall > 0) begin
            stall--;
            rsp_stream.ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall = $urandom_range(1, 11) - 1;
            rsp_stream.ready <= 1'b0;
         end else begin
            rsp_stream.ready <= 1'b1;
         end
      end
   end

   // watchdog: too long with no item moving on either channel
   always @(posedge clock) begin
      if (reset || (req_stream.valid && req_stream.ready) ||
          (rsp_stream.valid && rsp_stream.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
